@@ hw/rtl/bpl_pkg.sv @@
// shared types, constants and op codes of the breakpoint line table
package bpl_pkg;

  localparam int DEF_MAX_LENGTH = 4096;
  localparam int IDX_W  = 13;
  localparam int VAL_W  = 24;
  localparam int MAG_W  = 41;
  localparam int QUO_W  = MAG_W + 1;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(MAG_W);

  localparam logic signed [QUO_W-1:0] Q_MAX = QUO_W'(signed'(8388607));
  localparam logic signed [QUO_W-1:0] Q_MIN = -QUO_W'(signed'(8388608));

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_NORM  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [VAL_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUO_W-1:0]  quot;
  } div_rsp_t;

endpackage

@@ hw/rtl/bpl_div.sv @@
// shared restoring divider, one quotient bit per cycle
module bpl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bpl_pkg::div_req_t req,
  output bpl_pkg::div_rsp_t rsp
);
  import bpl_pkg::*;

  logic [VAL_W:0]     rem_r, rem_nxt, rem_sh;
  logic [MAG_W-1:0]   quo_r, quo_nxt;
  logic [VAL_W-1:0]   dvs_r;
  logic               neg_r;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic               ge;

  always_comb begin
    rem_sh   = {rem_r[VAL_W-1:0], quo_r[MAG_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.mag;
      cnt_nxt = DIV_STEPS;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_nxt  = {quo_r[MAG_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
      neg_r <= req.neg;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

@@ hw/rtl/bpl_store.sv @@
// table memory, one write and one registered read port, valid mark in the top bit
module bpl_store #(
  parameter int DEPTH = bpl_pkg::DEF_MAX_LENGTH + 2,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = bpl_pkg::VAL_W + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/breakpoint_line_table.sv @@
// top level: sequencer of the breakpoint line table around a shared divider and table memory
//
//  channel | direction | handshake      | beat carries
//  in_     | input     | valid / stall  | op, bp_time, bp_value, read_index
//  out_    | output    | valid / stall  | entry_index, entry_value
//  cfg_    | input     | valid / ready  | table_length
//
// work: read loads one entry, clear sweeps all MAX_LENGTH+2 entries, breakpoint divides once
//   and fills its entries; normalise scans for the peak then divides per written entry
// reset: a sweep of MAX_LENGTH+2 entries clears the valid marks, in_stall is high meanwhile
// one item at a time; in_stall stays high until the item's work is done
// a waiting result holds in the output register; a read waits on it while out_stall is high
module breakpoint_line_table #(
  parameter int MAX_LENGTH = bpl_pkg::DEF_MAX_LENGTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic [bpl_pkg::IDX_W-1:0]            in_bp_time,
  input  logic signed [bpl_pkg::VAL_W-1:0]     in_bp_value,
  input  logic [bpl_pkg::IDX_W-1:0]            in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bpl_pkg::IDX_W-1:0]            out_entry_index,
  output logic signed [bpl_pkg::VAL_W-1:0]     out_entry_value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpl_pkg::IDX_W-1:0]            cfg_table_length
);
  import bpl_pkg::*;

  localparam int DEPTH = MAX_LENGTH + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int DW    = VAL_W + 1;
  localparam int RST_LEN = (MAX_LENGTH < 4096) ? MAX_LENGTH : 4096;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] MAXL_C  = CW'(MAX_LENGTH);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_BP_DIV = 4'd2;
  localparam logic [3:0] S_FILL   = 4'd3;
  localparam logic [3:0] S_PEAK   = 4'd4;
  localparam logic [3:0] S_NM_RD  = 4'd5;
  localparam logic [3:0] S_NM_CHK = 4'd6;
  localparam logic [3:0] S_NM_DIV = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;

  logic [3:0]               state_r, state_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            end_r, end_nxt;
  logic [CW-1:0]            len_r;
  logic [IDX_W-1:0]         prev_time_r, prev_time_nxt;
  logic signed [VAL_W-1:0]  prev_level_r, prev_level_nxt;
  logic                     have_first_r, have_first_nxt;
  logic signed [47:0]       acc_r, acc_nxt;
  logic signed [QUO_W-1:0]  incr_r, incr_nxt;
  logic [VAL_W-2:0]         peak_r, peak_nxt;
  logic                     pk_vld_r, pk_vld_nxt;
  logic                     hit_r, hit_nxt;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic                     out_load;
  logic [IDX_W-1:0]         rd_index_r;

  // memory port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     accept;
  logic [CW-1:0]            cfg_ext;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W-1:0]         diff_mag;
  logic [VAL_W-1:0]         rd_mag;
  logic signed [VAL_W-1:0]  rd_val;
  logic signed [QUO_W-1:0]  sat_q;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_ext   = {{(CW-IDX_W){1'b0}}, cfg_table_length};

  // segment slope numerator, magnitude of the level step
  assign diff     = in_bp_value - prev_level_r;
  assign diff_mag = VAL_W'(diff[VAL_W] ? -diff : diff);
  assign rd_val   = rdata[VAL_W-1:0];
  assign rd_mag   = rd_val[VAL_W-1] ? -rd_val : rd_val;

  // divider result clipped to the entry range
  always_comb begin
    if (div_rsp.quot > Q_MAX) begin
      sat_q = Q_MAX;
    end else if (div_rsp.quot < Q_MIN) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = div_rsp.quot;
    end
  end

  assign out_load = (state_r == S_RD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    prev_time_nxt  = prev_time_r;
    prev_level_nxt = prev_level_r;
    have_first_nxt = have_first_r;
    acc_nxt        = acc_r;
    incr_nxt       = incr_r;
    peak_nxt       = peak_r;
    pk_vld_nxt     = 1'b0;
    hit_nxt        = hit_r;
    we             = 1'b0;
    waddr          = idx_r[AW-1:0];
    wdata          = '0;
    re             = 1'b0;
    raddr          = idx_r[AW-1:0];
    div_req        = '0;
    unique case (state_r)
      S_CLR: begin
        // sweep the whole store, clearing every valid mark
        we      = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == DEPTH_C - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_CLEAR: begin
              idx_nxt        = '0;
              prev_time_nxt  = '0;
              prev_level_nxt = '0;
              have_first_nxt = 1'b0;
              state_nxt      = S_CLR;
            end
            OP_POINT: begin
              prev_time_nxt  = in_bp_time;
              prev_level_nxt = in_bp_value;
              have_first_nxt = 1'b1;
              if (have_first_r && (in_bp_time > prev_time_r)) begin
                div_req.start   = 1'b1;
                div_req.neg     = diff[VAL_W];
                div_req.mag     = {1'b0, diff_mag, 16'd0};
                div_req.divisor = VAL_W'(in_bp_time - prev_time_r);
                idx_nxt   = {{(CW-IDX_W){1'b0}}, prev_time_r};
                end_nxt   = {{(CW-IDX_W){1'b0}}, in_bp_time};
                acc_nxt   = {{8{prev_level_r[VAL_W-1]}}, prev_level_r, 16'd0};
                state_nxt = S_BP_DIV;
              end
            end
            OP_NORM: begin
              idx_nxt   = '0;
              peak_nxt  = '0;
              state_nxt = S_PEAK;
            end
            OP_READ: begin
              hit_nxt   = ({{(CW-IDX_W){1'b0}}, in_read_index} < DEPTH_C);
              re        = 1'b1;
              raddr     = AW'(in_read_index);
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_BP_DIV: begin
        if (div_rsp.done) begin
          incr_nxt  = div_rsp.quot;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if ((idx_r < end_r) && (idx_r < len_r + CW'(2))) begin
          we      = 1'b1;
          wdata   = {1'b1, acc_r[16 +: VAL_W]};
          acc_nxt = acc_r + 48'(incr_r);
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PEAK: begin
        // one read per cycle, the compare follows in the cycle after each read
        if (idx_r < len_r) begin
          re         = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          pk_vld_nxt = 1'b1;
        end
        if (pk_vld_r && rdata[VAL_W] && !rd_val[VAL_W-1]
            && (rd_val[VAL_W-2:0] > peak_r)) begin
          peak_nxt = rd_val[VAL_W-2:0];
        end
        if (!(idx_r < len_r) && !pk_vld_r) begin
          idx_nxt   = '0;
          state_nxt = (peak_r != '0) ? S_NM_RD : S_IDLE;
        end
      end
      S_NM_RD: begin
        if (idx_r < len_r) begin
          re        = 1'b1;
          state_nxt = S_NM_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_NM_CHK: begin
        if (rdata[VAL_W]) begin
          div_req.start   = 1'b1;
          div_req.neg     = rd_val[VAL_W-1];
          div_req.mag     = {1'b0, rd_mag, 16'd0};
          div_req.divisor = {1'b0, peak_r};
          state_nxt       = S_NM_DIV;
        end else begin
          // never written entries stay unwritten
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_NM_RD;
        end
      end
      S_NM_DIV: begin
        if (div_rsp.done) begin
          we        = 1'b1;
          wdata     = {1'b1, sat_q[VAL_W-1:0]};
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_NM_RD;
        end
      end
      S_RD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      idx_r        <= '0;
      prev_time_r  <= '0;
      prev_level_r <= '0;
      have_first_r <= 1'b0;
      pk_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      len_r        <= CW'(RST_LEN);
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      prev_time_r  <= prev_time_nxt;
      prev_level_r <= prev_level_nxt;
      have_first_r <= have_first_nxt;
      pk_vld_r     <= pk_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // length write, clamped to 1..MAX_LENGTH
      if (cfg_valid && cfg_ready) begin
        if (cfg_ext == '0) begin
          len_r <= CW'(1);
        end else if (cfg_ext > MAXL_C) begin
          len_r <= MAXL_C;
        end else begin
          len_r <= cfg_ext;
        end
      end
    end
    end_r  <= end_nxt;
    acc_r  <= acc_nxt;
    incr_r <= incr_nxt;
    peak_r <= peak_nxt;
    hit_r  <= hit_nxt;
    if (accept) begin
      rd_index_r <= in_read_index;
    end
    if (out_load) begin
      out_index_r <= rd_index_r;
      out_value_r <= (hit_r && rdata[VAL_W]) ? rd_val : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_index_r;
  assign out_entry_value = out_value_r;

  bpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bpl_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // memory writes come only from the clear sweep, the fill and the normalise write-back
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLR || state_r == S_FILL || state_r == S_NM_DIV))
    else $error("table write outside a writing state");

  // a new result only follows a read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RD)
    else $error("result beat without a read");

  // divider finishes only while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_BP_DIV || state_r == S_NM_DIV))
    else $error("divider done with no waiting state");

  // fill stays below the guard limit
  a_fill_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && we) |-> (idx_r < len_r + CW'(2)))
    else $error("fill beyond table length");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the breakpoint line table: directed rows, then random beats
module tb_top;
  import bpl_pkg::*;

  localparam int DEPTH = DEF_MAX_LENGTH + 2;
  localparam int QUIET_LIMIT = 1000000;

  typedef struct {
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
  } entry_t;

  typedef struct {
    logic [1:0] op;
    int         t;
    int         v;
    int         idx;
    bit         typed;
    int         want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_op;
  logic [IDX_W-1:0] in_bp_time, in_read_index;
  logic signed [VAL_W-1:0] in_bp_value;
  logic out_valid, out_stall;
  logic [IDX_W-1:0] out_entry_index;
  logic signed [VAL_W-1:0] out_entry_value;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_table_length;

  // shadow copy of the table and segment state
  logic signed [VAL_W-1:0] level_mem [DEPTH];
  bit                      written [DEPTH];
  int                      tbl_len;
  int                      last_t;
  longint                  last_level;
  bit                      started;

  entry_t pending_reads [$];
  int     fails = 0;
  int     quiet = 0;
  int     idle_mode = 0;   // 0: sender 34 / receiver 53, 1: swapped, 2: no idling

  breakpoint_line_table i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stall, compare each beat with the oldest pending read
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected beat: entry_index %0d entry_value %0d", out_entry_index,
               out_entry_value);
        fails++;
      end else begin
        entry_t exp_e;
        exp_e = pending_reads.pop_front();
        if (out_entry_index !== exp_e.idx) begin
          $error("entry_index: expected %0d, got %0d", exp_e.idx, out_entry_index);
          fails++;
        end
        if (out_entry_value !== exp_e.val) begin
          $error("entry_value: expected %0d, got %0d", exp_e.val, out_entry_value);
          fails++;
        end
      end
    end
    case (idle_mode)
      0: out_stall <= ($urandom_range(99) < 53);
      1: out_stall <= ($urandom_range(99) < 34);
      default: out_stall <= 1'b0;
    endcase
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // linear segment from the previous breakpoint, floor of the q16 accumulator
  task automatic add_point(int t, longint lvl);
    longint incr, acc, e;
    if (started && t > last_t) begin
      incr = ((lvl - last_level) * 65536) / (t - last_t);
      acc = last_level * 65536;
      for (int i = last_t; i < t && i < tbl_len + 2 && i < DEPTH; i++) begin
        e = acc >>> 16;
        if (e > 8388607) e = 8388607;
        if (e < -8388608) e = -8388608;
        level_mem[i] = VAL_W'(e);
        written[i] = 1'b1;
        acc += incr;
      end
    end
    last_t = t;
    last_level = lvl;
    started = 1'b1;
  endtask

  task automatic scale_to_peak();
    longint peak, q;
    peak = 0;
    for (int n = 0; n < tbl_len; n++)
      if (written[n] && longint'(level_mem[n]) > peak) peak = level_mem[n];
    if (peak > 0) begin
      for (int n = 0; n < tbl_len; n++) begin
        if (written[n]) begin
          q = (longint'(level_mem[n]) * 65536) / peak;
          if (q > 8388607) q = 8388607;
          if (q < -8388608) q = -8388608;
          level_mem[n] = VAL_W'(q);
        end
      end
    end
  endtask

  // update the shadow state for one accepted beat, queue the read result
  task automatic apply_beat(logic [1:0] op, int t, int v, int idx, bit typed, int want);
    entry_t e;
    case (op)
      OP_CLEAR: begin
        foreach (written[i]) written[i] = 1'b0;
        last_t = 0;
        last_level = 0;
        started = 1'b0;
      end
      OP_POINT: add_point(t, longint'(v));
      OP_NORM:  scale_to_peak();
      default: begin
        e.idx = IDX_W'(idx);
        if (typed)
          e.val = VAL_W'(want);
        else if (idx < DEPTH && written[idx])
          e.val = level_mem[idx];
        else
          e.val = '0;
        pending_reads.push_back(e);
      end
    endcase
  endtask

  task automatic send_beat(logic [1:0] op, int t, int v, int idx, bit typed, int want);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 34 : (idle_mode == 1) ? 53 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_bp_time    <= IDX_W'(t);
    in_bp_value   <= VAL_W'(v);
    in_read_index <= IDX_W'(idx);
    do @(posedge clk); while (in_stall);
    apply_beat(op, t, v, idx, typed, want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // register write only once the block is idle again
  task automatic write_length(int len);
    drain();
    while (in_stall) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_table_length <= IDX_W'(len);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_len = (len < 1) ? 1 : (len > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : len;
  endtask

  function automatic int written_count();
    int c = 0;
    for (int n = 0; n < tbl_len; n++) c += written[n];
    return c;
  endfunction

  // directed rows: table length is still the reset value
  row_t dir_rows [22] = '{
    '{OP_READ,  0,    0,        0,    1'b1, 0},         // after reset
    '{OP_READ,  0,    0,        8191, 1'b1, 0},         // out of store
    '{OP_READ,  0,    0,        4097, 1'b1, 0},         // last guard
    '{OP_POINT, 0,    0,        0,    1'b0, 0},         // first point only records
    '{OP_READ,  0,    0,        0,    1'b1, 0},
    '{OP_POINT, 4,    262144,   0,    1'b0, 0},
    '{OP_READ,  0,    0,        2,    1'b1, 131072},
    '{OP_POINT, 4,    100,      0,    1'b0, 0},         // zero length
    '{OP_POINT, 2,    -8388608, 0,    1'b0, 0},         // backward
    '{OP_POINT, 3,    8388607,  0,    1'b0, 0},
    '{OP_READ,  0,    0,        2,    1'b1, -8388608},
    '{OP_READ,  0,    0,        3,    1'b1, 196608},
    '{OP_NORM,  0,    0,        0,    1'b0, 0},
    '{OP_READ,  0,    0,        1,    1'b0, 0},
    '{OP_READ,  0,    0,        2,    1'b0, 0},
    '{OP_POINT, 8191, 8388607,  0,    1'b0, 0},         // runs past the guards
    '{OP_READ,  0,    0,        4097, 1'b0, 0},
    '{OP_CLEAR, 0,    0,        0,    1'b0, 0},
    '{OP_READ,  0,    0,        3,    1'b1, 0},
    '{OP_NORM,  0,    0,        0,    1'b0, 0},         // empty table, peak zero
    '{OP_POINT, 4097, -1,       0,    1'b0, 0},
    '{OP_READ,  0,    0,        4097, 1'b1, 0}
  };

  int phase_len [6] = '{0, 8191, 17, 4096, 3, 40};

  initial begin
    int cursor, roll, t, v, idx;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_op            <= OP_CLEAR;
    in_bp_time       <= '0;
    in_bp_value      <= '0;
    in_read_index    <= '0;
    out_stall        <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_table_length <= '0;
    foreach (written[i]) written[i] = 1'b0;
    tbl_len = DEF_MAX_LENGTH;
    last_t = 0;
    last_level = 0;
    started = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      send_beat(dir_rows[r].op, dir_rows[r].t, dir_rows[r].v, dir_rows[r].idx,
                dir_rows[r].typed, dir_rows[r].want);

    cursor = 0;
    for (int p = 0; p < 6; p++) begin
      write_length(phase_len[p]);
      idle_mode = p / 2;
      for (int k = 0; k < 272; k++) begin
        // hold the sender until every read has come back
        if (p == 1 && k == 136) drain();
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_beat(OP_CLEAR, 0, 0, 0, 1'b0, 0);
          cursor = 0;
        end else if (roll < 50) begin
          // mostly rising times with small steps, sometimes a jump anywhere
          if ($urandom_range(9) == 0)
            t = $urandom_range(8191);
          else if ($urandom_range(5) == 0)
            t = $urandom_range(tbl_len + 3);
          else
            t = cursor + $urandom_range(12);
          if (t > 8191) t = $urandom_range(20);
          cursor = t;
          v = $urandom;
          v = (v <<< 8) >>> 8;
          if ($urandom_range(3) == 0) v = v >>> $urandom_range(20);
          send_beat(OP_POINT, t, v, 0, 1'b0, 0);
        end else if (roll < 56) begin
          // keep the divider pass short while the table is long
          if (tbl_len <= 64 || written_count() < 300)
            send_beat(OP_NORM, 0, 0, 0, 1'b0, 0);
        end else begin
          idx = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(tbl_len + 3);
          send_beat(OP_READ, 0, 0, idx, 1'b0, 0);
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0 && pending_reads.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bpl_pkg.sv
hw/rtl/bpl_div.sv
hw/rtl/bpl_store.sv
hw/rtl/breakpoint_line_table.sv
tb/tb_top.sv
